@@ hdl/hrhs_pkg.sv @@
`default_nettype none

package hrhs_pkg;

  localparam int unsigned HIT_W       = 24;
  localparam int unsigned SYM_FIELD_W = 16;
  localparam int unsigned MOD_W       = 8;
  localparam int unsigned IDX_FIELD_W = 20;
  localparam int unsigned GAP_W       = 20;
  localparam int unsigned TOTAL_W     = 44;
  localparam int unsigned MOMENT_W    = 64;
  localparam int unsigned DIV_CNT_W   = $clog2(MOMENT_W);

  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 112;

  localparam int unsigned IN_HIT_LSB  = 0;
  localparam int unsigned IN_SYM_LSB  = 24;
  localparam int unsigned IN_MOD_LSB  = 40;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = TOTAL_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_GAP = 2'd2;

  localparam logic [HIT_W-1:0]   SAMPLE_THR_RST  = 24'd1;
  localparam logic [TOTAL_W-1:0] HOTSPOT_THR_RST = 44'd2;
  localparam logic [GAP_W-1:0]   CONTEXT_GAP_RST = 20'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic take;
    logic accum;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic report;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/hrhs_div.sv @@
`default_nettype none

module hrhs_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [hrhs_pkg::MOMENT_W-1:0]      dividend_i,
  input  wire logic [hrhs_pkg::TOTAL_W-1:0]       divisor_i,
  output logic                                    done_o,
  output logic [hrhs_pkg::MOMENT_W-1:0]           quot_o
);

  logic [hrhs_pkg::MOMENT_W-1:0]  quot_q, quot_d;
  logic [hrhs_pkg::TOTAL_W-1:0]   rem_q, rem_d;
  logic [hrhs_pkg::TOTAL_W-1:0]   dsr_q, dsr_d;
  logic [hrhs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [hrhs_pkg::TOTAL_W:0]     trial;
  logic [hrhs_pkg::TOTAL_W:0]     diff;
  logic                           ge;

  always_comb begin
    trial  = {rem_q, quot_q[hrhs_pkg::MOMENT_W-1]};
    diff   = trial - {1'b0, dsr_q};
    ge     = (trial >= {1'b0, dsr_q});
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[hrhs_pkg::MOMENT_W-2:0], ge};
      rem_d  = ge ? diff[hrhs_pkg::TOTAL_W-1:0] : trial[hrhs_pkg::TOTAL_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ hdl/hrhs_datapath.sv @@
`default_nettype none

module hrhs_datapath #(
  parameter int unsigned MAX_ITEMS = 1048576,
  parameter int unsigned HIT_BITS  = 24,
  parameter int unsigned SYM_W     = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire hrhs_pkg::cmd_t                       cmd_i,
  output hrhs_pkg::status_t                         status_o,
  input  wire logic [hrhs_pkg::IN_DATA_W-1:0]       in_data_i,
  input  wire logic                                 in_last_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [hrhs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [hrhs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [hrhs_pkg::OUT_DATA_W-1:0]           out_data_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);
  localparam int unsigned PROD_W = HIT_BITS + IDX_W;
  localparam int unsigned CMP_W  = hrhs_pkg::GAP_W + 1;
  localparam logic [IDX_W-1:0] POS_MAX = IDX_W'(MAX_ITEMS - 1);

  logic [hrhs_pkg::HIT_W-1:0]   sthr_q;
  logic [hrhs_pkg::TOTAL_W-1:0] hthr_q;
  logic [hrhs_pkg::GAP_W-1:0]   gap_q;

  logic                          open_q, open_d;
  logic [SYM_W-1:0]              rsym_q, rsym_d;
  logic [IDX_W-1:0]              start_q, start_d;
  logic [IDX_W-1:0]              end_q, end_d;
  logic [hrhs_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic [hrhs_pkg::MOMENT_W-1:0] moment_q, moment_d;
  logic [IDX_W-1:0]              pos_q, pos_d;
  logic [PROD_W-1:0]             prod_q, prod_d;
  logic [IDX_W-1:0]              iidx_q;
  logic [SYM_W-1:0]              isym_q;
  logic [hrhs_pkg::MOD_W-1:0]    imod_q;
  logic                          ilast_q;
  logic                          ovalid_q, ovalid_d;
  logic [hrhs_pkg::OUT_DATA_W-1:0] odata_q, odata_d;

  logic [HIT_BITS-1:0]           hits;
  logic [SYM_W-1:0]              sym;
  logic                          hot;
  logic [IDX_W-1:0]              start_new;
  logic [hrhs_pkg::TOTAL_W-1:0]  total_base;
  logic [hrhs_pkg::TOTAL_W:0]    total_sum;
  logic [hrhs_pkg::MOMENT_W:0]   moment_sum;
  logic [hrhs_pkg::MOMENT_W-1:0] moment_sat;
  logic [CMP_W-1:0]              gap_lim;
  logic                          close;
  logic                          div_done;
  logic [hrhs_pkg::MOMENT_W-1:0] quot;
  logic [IDX_W-1:0]              span;
  logic [IDX_W-1:0]              centre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sthr_q <= hrhs_pkg::SAMPLE_THR_RST;
      hthr_q <= hrhs_pkg::HOTSPOT_THR_RST;
      gap_q  <= hrhs_pkg::CONTEXT_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hrhs_pkg::REG_SAMPLE_THR:  sthr_q <= cfg_data_i[hrhs_pkg::HIT_W-1:0];
        hrhs_pkg::REG_HOTSPOT_THR: hthr_q <= cfg_data_i;
        hrhs_pkg::REG_CONTEXT_GAP: gap_q  <= cfg_data_i[hrhs_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hits       = in_data_i[hrhs_pkg::IN_HIT_LSB +: HIT_BITS];
    sym        = in_data_i[hrhs_pkg::IN_SYM_LSB +: SYM_W];
    hot        = (hrhs_pkg::HIT_W'(hits) >= sthr_q);
    start_new  = open_q ? start_q : pos_q;
    total_base = open_q ? total_q : '0;
    total_sum  = {1'b0, total_base} + (hrhs_pkg::TOTAL_W + 1)'(hits);
    moment_sum = {1'b0, moment_q} + (hrhs_pkg::MOMENT_W + 1)'(prod_q);
    moment_sat = moment_sum[hrhs_pkg::MOMENT_W] ? '1 : moment_sum[hrhs_pkg::MOMENT_W-1:0];
    gap_lim    = {1'b0, gap_q} + CMP_W'(end_q);
    close      = open_q && ((CMP_W'(iidx_q) > gap_lim) || (isym_q != rsym_q) || ilast_q);
    span       = end_q - start_q;
    if (total_q == '0) begin
      centre = start_q;
    end else if (quot > hrhs_pkg::MOMENT_W'(span)) begin
      centre = end_q;
    end else begin
      centre = start_q + quot[IDX_W-1:0];
    end

    open_d   = open_q;
    rsym_d   = rsym_q;
    start_d  = start_q;
    end_d    = end_q;
    total_d  = total_q;
    moment_d = moment_q;
    pos_d    = pos_q;
    prod_d   = prod_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;

    if (cmd_i.take) begin
      prod_d = '0;
      if (hot) begin
        if (!open_q) begin
          rsym_d   = sym;
          moment_d = '0;
        end
        open_d  = 1'b1;
        start_d = start_new;
        end_d   = pos_q;
        total_d = total_sum[hrhs_pkg::TOTAL_W] ? '1 : total_sum[hrhs_pkg::TOTAL_W-1:0];
        prod_d  = hits * (pos_q - start_new);
      end
      if (in_last_i) begin
        pos_d = '0;
      end else if (pos_q < POS_MAX) begin
        pos_d = pos_q + 1'b1;
      end
    end

    if (cmd_i.accum) begin
      moment_d = moment_sat;
      if (close) begin
        open_d = 1'b0;
      end
    end

    if (cmd_i.load) begin
      ovalid_d = 1'b1;
      odata_d  = {total_q,
                  hrhs_pkg::IDX_FIELD_W'(centre),
                  hrhs_pkg::IDX_FIELD_W'(end_q),
                  hrhs_pkg::IDX_FIELD_W'(start_q),
                  imod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      rsym_q   <= '0;
      start_q  <= '0;
      end_q    <= '0;
      total_q  <= '0;
      moment_q <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      open_q   <= open_d;
      rsym_q   <= rsym_d;
      start_q  <= start_d;
      end_q    <= end_d;
      total_q  <= total_d;
      moment_q <= moment_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    odata_q <= odata_d;
    if (cmd_i.take) begin
      iidx_q  <= pos_q;
      isym_q  <= sym;
      imod_q  <= in_data_i[hrhs_pkg::IN_MOD_LSB +: hrhs_pkg::MOD_W];
      ilast_q <= in_last_i;
    end
  end

  hrhs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (moment_sat),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign status_o.report   = close && (total_q >= hthr_q);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o       = ovalid_q;
  assign out_data_o        = odata_q;

endmodule

`default_nettype wire

@@ hdl/hrhs_ctrl.sv @@
`default_nettype none

module hrhs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hrhs_pkg::status_t status_i,
  output hrhs_pkg::cmd_t         cmd_o
);

  hrhs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrhs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      hrhs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = hrhs_pkg::ST_ACCUM;
        end
      end
      hrhs_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (status_i.report) begin
          cmd_o.div_start = 1'b1;
          state_d         = hrhs_pkg::ST_DIV;
        end else begin
          state_d = hrhs_pkg::ST_IDLE;
        end
      end
      hrhs_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = hrhs_pkg::ST_LOAD;
        end
      end
      hrhs_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = hrhs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hrhs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/hit_run_hotspot_segmenter_top.sv @@
// Channel  Direction  Handshake                     Payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata hit_count, symbol_id, module_id; tlast
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata hot_module .. total_hits
// cfg      in         cfg_we_i                      cfg_idx_i, cfg_data_i
//
// An item is accepted with its run update in ST_IDLE, then gets its moment add
// and close check in ST_ACCUM. An item that closes a reported run then passes the
// radix-2 divider in ST_DIV (64 steps of moment over total, then done is seen) and
// ST_LOAD, which loads the output register once the output side is free.
// The output register frees the input side; a stalled output holds only a later report.
// Reset is asynchronous and active low; no clearing pass follows it.
`default_nettype none

module hit_run_hotspot_segmenter_top #(
  parameter int unsigned MAX_ITEMS   = 1048576,
  parameter int unsigned HIT_BITS    = 24,
  parameter int unsigned SYMBOL_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // hit_count[23:0], symbol_id[39:24], module_id[47:40]
  input  wire logic [hrhs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // hot_module[7:0], first_index[27:8], final_index[47:28],
  // centre_index[67:48], total_hits[111:68]
  output logic [hrhs_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [hrhs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [hrhs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SYM_W = (SYMBOL_BITS < hrhs_pkg::SYM_FIELD_W) ?
                                  SYMBOL_BITS : hrhs_pkg::SYM_FIELD_W;

  hrhs_pkg::cmd_t    cmd;
  hrhs_pkg::status_t status;

  hrhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hrhs_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .HIT_BITS  (HIT_BITS),
    .SYM_W     (SYM_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ hdl/hrhs_checker.sv @@
`default_nettype none

module hrhs_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [hrhs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  logic [hrhs_pkg::IDX_FIELD_W-1:0] first_idx;
  logic [hrhs_pkg::IDX_FIELD_W-1:0] final_idx;
  logic [hrhs_pkg::IDX_FIELD_W-1:0] centre_idx;

  assign first_idx  = m_axis_tdata[27:8];
  assign final_idx  = m_axis_tdata[47:28];
  assign centre_idx = m_axis_tdata[67:48];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on two consecutive cycles");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> first_idx <= final_idx)
    else $error("run start past run end");

  a_centre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> first_idx <= centre_idx && centre_idx <= final_idx)
    else $error("centre outside run");

endmodule

bind hit_run_hotspot_segmenter_top hrhs_checker u_hrhs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb_hit_run_hotspot_segmenter_top.sv @@
module tb_hit_run_hotspot_segmenter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hrhs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 85;

  typedef struct packed {
    logic [hrhs_pkg::HIT_W-1:0]       hits;
    logic [hrhs_pkg::SYM_FIELD_W-1:0] sym;
    logic [hrhs_pkg::MOD_W-1:0]       mod_id;
    logic                             last;
  } instr_t;

  typedef struct packed {
    logic [hrhs_pkg::TOTAL_W-1:0]     total;
    logic [hrhs_pkg::IDX_FIELD_W-1:0] centre_idx;
    logic [hrhs_pkg::IDX_FIELD_W-1:0] final_idx;
    logic [hrhs_pkg::IDX_FIELD_W-1:0] first_idx;
    logic [hrhs_pkg::MOD_W-1:0]       mod;
  } hotspot_t;

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hrhs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hrhs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_we_i = 1'b0;
  logic [hrhs_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [hrhs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  hit_run_hotspot_segmenter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor copy of registers and run state
  logic [hrhs_pkg::HIT_W-1:0]       thr_sample  = hrhs_pkg::SAMPLE_THR_RST;
  logic [hrhs_pkg::TOTAL_W-1:0]     thr_hotspot = hrhs_pkg::HOTSPOT_THR_RST;
  logic [hrhs_pkg::GAP_W-1:0]       ctx_gap     = hrhs_pkg::CONTEXT_GAP_RST;
  logic                             run_open    = 1'b0;
  logic [hrhs_pkg::SYM_FIELD_W-1:0] run_sym     = '0;
  logic [hrhs_pkg::IDX_FIELD_W-1:0] run_start   = '0;
  logic [hrhs_pkg::IDX_FIELD_W-1:0] run_end     = '0;
  logic [hrhs_pkg::TOTAL_W-1:0]     run_total   = '0;
  logic [hrhs_pkg::MOMENT_W-1:0]    run_moment  = '0;
  logic [hrhs_pkg::IDX_FIELD_W-1:0] position    = '0;

  hotspot_t hotspot_q[$];
  hotspot_t seen_hs;
  hotspot_t want_hs;
  int fail_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_hs = hotspot_t'(m_axis_tdata);
      if (hotspot_q.size() == 0) begin
        $display("%0t: unexpected hotspot, expected none, actual %h", $time, seen_hs);
        fail_count++;
      end else begin
        want_hs = hotspot_q.pop_front();
        check_field("hot_module", want_hs.mod, seen_hs.mod);
        check_field("first_index", want_hs.first_idx, seen_hs.first_idx);
        check_field("final_index", want_hs.final_idx, seen_hs.final_idx);
        check_field("centre_index", want_hs.centre_idx, seen_hs.centre_idx);
        check_field("total_hits", want_hs.total, seen_hs.total);
      end
    end
  end

  task automatic close_run(input logic [hrhs_pkg::MOD_W-1:0] mod);
    hotspot_t h;
    logic [hrhs_pkg::MOMENT_W:0] centre;
    run_open = 1'b0;
    if (run_total >= thr_hotspot) begin
      if (run_total == '0)
        centre = (hrhs_pkg::MOMENT_W+1)'(run_start);
      else
        centre = (hrhs_pkg::MOMENT_W+1)'(run_start) +
                 (hrhs_pkg::MOMENT_W+1)'(run_moment / hrhs_pkg::MOMENT_W'(run_total));
      if (centre > (hrhs_pkg::MOMENT_W+1)'(run_end))
        centre = (hrhs_pkg::MOMENT_W+1)'(run_end);
      h.mod        = mod;
      h.first_idx  = run_start;
      h.final_idx  = run_end;
      h.centre_idx = centre[hrhs_pkg::IDX_FIELD_W-1:0];
      h.total      = run_total;
      hotspot_q.push_back(h);
    end
  endtask

  task automatic track_hit_run(input instr_t it);
    logic [hrhs_pkg::IDX_FIELD_W-1:0] idx;
    logic [hrhs_pkg::TOTAL_W:0]       tot_sum;
    logic [hrhs_pkg::MOMENT_W:0]      mom_sum;
    logic [hrhs_pkg::TOTAL_W-1:0]     prod;
    idx = position;
    if (it.hits >= thr_sample) begin
      if (!run_open) begin
        run_sym    = it.sym;
        run_start  = idx;
        run_total  = '0;
        run_moment = '0;
        run_open   = 1'b1;
      end
      tot_sum = {1'b0, run_total} + (hrhs_pkg::TOTAL_W+1)'(it.hits);
      run_total = tot_sum[hrhs_pkg::TOTAL_W] ? '1 : tot_sum[hrhs_pkg::TOTAL_W-1:0];
      prod = hrhs_pkg::TOTAL_W'(it.hits) * hrhs_pkg::TOTAL_W'(idx - run_start);
      mom_sum = {1'b0, run_moment} + (hrhs_pkg::MOMENT_W+1)'(prod);
      run_moment = mom_sum[hrhs_pkg::MOMENT_W] ? '1 : mom_sum[hrhs_pkg::MOMENT_W-1:0];
      run_end = idx;
    end
    if (run_open &&
        (({1'b0, idx} > {1'b0, run_end} + (hrhs_pkg::IDX_FIELD_W+1)'(ctx_gap)) ||
         it.sym != run_sym))
      close_run(it.mod_id);
    if (it.last) begin
      if (run_open)
        close_run(it.mod_id);
      position = '0;
    end else if (position != '1) begin
      position = position + 1'b1;
    end
  endtask

  task automatic send_item(input instr_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.mod_id, it.sym, it.hits};
    s_axis_tlast  <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_hit_run(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hotspot_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [hrhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hrhs_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      hrhs_pkg::REG_SAMPLE_THR:  thr_sample  = val[hrhs_pkg::HIT_W-1:0];
      hrhs_pkg::REG_HOTSPOT_THR: thr_hotspot = val[hrhs_pkg::TOTAL_W-1:0];
      hrhs_pkg::REG_CONTEXT_GAP: ctx_gap     = val[hrhs_pkg::GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [hrhs_pkg::HIT_W-1:0] smp,
                            input logic [hrhs_pkg::TOTAL_W-1:0] hot,
                            input logic [hrhs_pkg::GAP_W-1:0] gap);
    drain();
    write_reg(hrhs_pkg::REG_SAMPLE_THR, hrhs_pkg::CFG_DATA_W'(smp));
    write_reg(hrhs_pkg::REG_HOTSPOT_THR, hrhs_pkg::CFG_DATA_W'(hot));
    write_reg(hrhs_pkg::REG_CONTEXT_GAP, hrhs_pkg::CFG_DATA_W'(gap));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic instr_t mk(logic [hrhs_pkg::HIT_W-1:0] hits,
                                logic [hrhs_pkg::SYM_FIELD_W-1:0] sym,
                                logic [hrhs_pkg::MOD_W-1:0] mod, logic last);
    instr_t it;
    it.hits   = hits;
    it.sym    = sym;
    it.mod_id = mod;
    it.last   = last;
    return it;
  endfunction

  function automatic logic [hrhs_pkg::HIT_W-1:0] pick_hits(bit hot);
    logic [hrhs_pkg::HIT_W:0] h;
    if (hot || thr_sample == '0) begin
      case ($urandom_range(0, 4))
        0: h = (hrhs_pkg::HIT_W+1)'(thr_sample);
        1: h = (hrhs_pkg::HIT_W+1)'({hrhs_pkg::HIT_W{1'b1}});
        2: h = (hrhs_pkg::HIT_W+1)'($urandom_range(int'(thr_sample), 32'hFFFFFF));
        default: h = (hrhs_pkg::HIT_W+1)'(thr_sample) +
                     (hrhs_pkg::HIT_W+1)'($urandom_range(0, 300));
      endcase
      if (h > (hrhs_pkg::HIT_W+1)'({hrhs_pkg::HIT_W{1'b1}}))
        h = (hrhs_pkg::HIT_W+1)'({hrhs_pkg::HIT_W{1'b1}});
    end else begin
      case ($urandom_range(0, 2))
        0: h = (hrhs_pkg::HIT_W+1)'(thr_sample - 1'b1);
        1: h = '0;
        default: h = (hrhs_pkg::HIT_W+1)'($urandom_range(0, int'(thr_sample) - 1));
      endcase
    end
    return h[hrhs_pkg::HIT_W-1:0];
  endfunction

  function automatic logic [hrhs_pkg::SYM_FIELD_W-1:0] pick_symbol();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return hrhs_pkg::SYM_FIELD_W'($urandom_range(0, 3));
      default: return hrhs_pkg::SYM_FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // bursts of mostly hot items separated by cold stretches around the context gap
  task automatic send_module(inout int sent);
    instr_t it;
    int len, k, hot_left, cold_left, cold_max;
    bit hot;
    it.mod_id = hrhs_pkg::MOD_W'($urandom_range(0, 255));
    it.sym    = pick_symbol();
    len       = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
    cold_max  = (ctx_gap > 10) ? 12 : int'(ctx_gap) + 2;
    hot_left  = 0;
    cold_left = 0;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 6)
        it.sym = $urandom_range(0, 1) ? pick_symbol() : it.sym ^ 1'b1;
      if ($urandom_range(0, 99) < 2)
        it.mod_id = hrhs_pkg::MOD_W'($urandom_range(0, 255));
      if (hot_left == 0 && cold_left == 0) begin
        hot_left  = $urandom_range(1, 6);
        cold_left = $urandom_range(0, cold_max);
      end
      if (hot_left > 0) begin
        hot = ($urandom_range(0, 99) < 80);
        hot_left--;
      end else begin
        hot = 1'b0;
        cold_left--;
      end
      it.hits = pick_hits(hot);
      it.last = (k == len - 1);
      send_item(it);
      sent++;
    end
  endtask

  task automatic test_reset_config();
    send_item(mk(24'd1, 16'h0000, 8'h00, 1'b0));
    send_item(mk(24'd0, 16'h0000, 8'h00, 1'b0));
    send_item(mk(24'd3, 16'h0000, 8'h00, 1'b0));
    send_item(mk(24'd0, 16'h0000, 8'h00, 1'b1));
    drain();
  endtask

  task automatic test_symbol_change();
    send_item(mk(24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0));
    send_item(mk(24'd5, 16'h0000, 8'hFF, 1'b0));
    send_item(mk(24'd2, 16'h1234, 8'h80, 1'b0));
    send_item(mk(24'd0, 16'h4321, 8'h7F, 1'b1));
    drain();
  endtask

  task automatic test_gap_limits();
    set_config(24'd1, 44'd2, '0);
    send_item(mk(24'd4, 16'h00A5, 8'h01, 1'b0));
    send_item(mk(24'd0, 16'h00A5, 8'h01, 1'b0));
    send_item(mk(24'd3, 16'h00A5, 8'h01, 1'b1));
    set_config(24'd1, 44'd2, '1);
    send_item(mk(24'd6, 16'h5A00, 8'h02, 1'b0));
    send_item(mk(24'd0, 16'h5A00, 8'h02, 1'b0));
    send_item(mk(24'd0, 16'h5A00, 8'h02, 1'b0));
    send_item(mk(24'd2, 16'h5A00, 8'h02, 1'b1));
    drain();
  endtask

  task automatic test_high_thresholds();
    set_config('1, '1, 20'd5);
    send_item(mk(24'hFFFFFF, 16'h0F0F, 8'h55, 1'b0));
    send_item(mk(24'hFFFFFF, 16'h0F0F, 8'h55, 1'b1));
    drain();
  endtask

  task automatic test_zero_total();
    set_config('0, '0, 20'd5);
    send_item(mk(24'd0, 16'd5, 8'h03, 1'b0));
    send_item(mk(24'd0, 16'd5, 8'h03, 1'b0));
    send_item(mk(24'd0, 16'd5, 8'h03, 1'b1));
    drain();
  endtask

  task automatic test_unused_index();
    set_config(24'd1, 44'd2, 20'd5);
    write_reg(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_item(mk(24'd1, 16'd9, 8'h04, 1'b0));
    send_item(mk(24'd1, 16'd9, 8'h04, 1'b1));
    drain();
  endtask

  task automatic test_random_traffic();
    int mode, cfg_sel, sent;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase
      for (cfg_sel = 0; cfg_sel < 5; cfg_sel++) begin
        case (cfg_sel)
          0: set_config(24'd1, 44'd2, 20'd5);
          1: set_config('0, '0, '0);
          2: set_config(24'd16, 44'd300, 20'd3);
          3: set_config('1, 44'h1000000, '1);
          default: set_config(hrhs_pkg::HIT_W'($urandom_range(0, 200)),
                              hrhs_pkg::TOTAL_W'($urandom_range(0, 5000)),
                              hrhs_pkg::GAP_W'($urandom_range(0, 12)));
        endcase
        sent = 0;
        while (sent < ITEMS_PER_PHASE) send_module(sent);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_config();
    test_symbol_change();
    test_gap_limits();
    test_high_thresholds();
    test_zero_total();
    test_unused_index();
    test_random_traffic();
    drain();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && hotspot_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/hrhs_pkg.sv
hdl/hrhs_div.sv
hdl/hrhs_datapath.sv
hdl/hrhs_ctrl.sv
hdl/hit_run_hotspot_segmenter_top.sv
hdl/hrhs_checker.sv
tb/tb_hit_run_hotspot_segmenter_top.sv
